// ===== rtl/core/pcr_pkg.sv =====
// Shared types and constants for the piecewise color ramp.
// No dependencies; used by piecewise_color_ramp_top and pcr_chk.
`timescale 1ns / 1ps

package pcr_pkg;

    // ramp geometry
    localparam int NUM_BREAKS = 7;   // break registers present
    localparam int MAX_BREAKS = 7;   // breaks the search will use
    localparam int CNT_W      = 3;
    localparam int POS_W      = 17;  // unsigned Q1.16, 0..131071
    localparam int IN_W       = 18;  // signed Q1.16 input
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int COL_W      = NUM_CH * CH_W;
    localparam int BRK_W      = POS_W + COL_W;
    localparam int CFG_IDX_W  = 3;

    // divider: quotient never exceeds the channel delta, so CH_W bits
    localparam int NUM_W      = CH_W + POS_W;
    localparam int DIV_STAGES = CH_W;

    // pipeline: clamp, search, span/delta, multiply, divide steps, output
    localparam int STG_CLAMP  = 0;
    localparam int STG_SEARCH = 1;
    localparam int STG_SPAN   = 2;
    localparam int STG_MUL    = 3;
    localparam int NUM_STG    = STG_MUL + DIV_STAGES + 2;

    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(65536);
    localparam logic [COL_W-1:0] COL_WHITE = '1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BRK0  = CFG_IDX_W'(1);

    typedef logic [NUM_CH-1:0][CH_W-1:0] t_color;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        t_color           color;
    } t_brk;

    // after segment search
    typedef struct packed {
        logic [POS_W-1:0] v;
        logic [POS_W-1:0] p1;
        logic [POS_W-1:0] p2;
        t_color           c1;
        t_color           c2;
        logic             fallback;
        logic             force_c1;
    } t_sb;

    // after span and channel deltas
    typedef struct packed {
        logic [POS_W-1:0] span;
        logic [POS_W-1:0] t;
        t_color           c1;
        t_color           mag;
        logic [NUM_CH-1:0] neg;
        logic             use_c1;
    } t_sc;

    // multiply / divide stages
    typedef struct packed {
        logic [NUM_CH-1:0][NUM_W-1:0] rem;
        t_color                       q;
        logic [POS_W-1:0]             span;
        t_color                       c1;
        logic [NUM_CH-1:0]            neg;
        logic                         use_c1;
    } t_dv;

endpackage

// ===== rtl/core/piecewise_color_ramp_top.sv =====
// Piecewise linear color ramp: position to RGB through up to seven breaks.
// Depends on pcr_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel : i_in_valid / o_in_ready, payload i_position (signed Q1.16).
//   Output channel: o_out_valid / i_out_ready, payload o_red, o_green, o_blue.
//   Config port   : i_cfg_we, i_cfg_index (0 = break count, 1..7 = breaks),
//                   i_cfg_data; write only while no transaction is in flight.
//   Throughput    : one transaction per cycle while not stalled (see Stalls).
//                   The pipeline has 13 stages: clamp, segment search,
//                   span/delta, multiply, eight restoring divide steps
//                   (one quotient bit each), output.
//   Stalls        : each stage with a valid bit moves on when the stage after
//                   it is empty or moving, so bubbles close up; o_in_ready only
//                   drops once every stage holds a transaction and the
//                   receiver holds i_out_ready low.
//   Reset         : synchronous, active low; empties the pipeline, clears the
//                   break count and all breaks (output is white until a count
//                   is written).
module piecewise_color_ramp_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic signed [pcr_pkg::IN_W-1:0] i_position,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pcr_pkg::CH_W-1:0]       o_red,
    output logic [pcr_pkg::CH_W-1:0]       o_green,
    output logic [pcr_pkg::CH_W-1:0]       o_blue,
    input  logic                           i_cfg_we,
    input  logic [pcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcr_pkg::BRK_W-1:0]      i_cfg_data
);

    // configuration
    logic [pcr_pkg::CNT_W-1:0] r_cnt;
    pcr_pkg::t_brk             r_brk [pcr_pkg::NUM_BREAKS];

    // pipeline control
    logic [pcr_pkg::NUM_STG-1:0] r_vld;
    logic [pcr_pkg::NUM_STG-1:0] en;

    // payload
    logic [pcr_pkg::POS_W-1:0] r_a_v, n_a_v;
    pcr_pkg::t_sb              r_sb, n_sb;
    pcr_pkg::t_sc              r_sc, n_sc;
    pcr_pkg::t_dv              r_dv [pcr_pkg::DIV_STAGES+1];
    pcr_pkg::t_dv              n_dv [pcr_pkg::DIV_STAGES+1];
    pcr_pkg::t_color           r_out, n_out;

    // search helpers
    logic [pcr_pkg::CNT_W-1:0]      n_eff;
    logic [pcr_pkg::NUM_BREAKS-1:0] hit;
    logic [pcr_pkg::NUM_BREAKS-1:0] seg;
    logic                           found;

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int i = 0; i < pcr_pkg::NUM_BREAKS; i++) begin
                r_brk[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == pcr_pkg::CFG_COUNT) begin
                r_cnt <= i_cfg_data[pcr_pkg::CNT_W-1:0];
            end
            for (int i = 0; i < pcr_pkg::NUM_BREAKS; i++) begin
                if (i_cfg_index == pcr_pkg::CFG_BRK0 + pcr_pkg::CFG_IDX_W'(i)) begin
                    r_brk[i] <= i_cfg_data;
                end
            end
        end
    end

    // ------------------------------------------------------ pipeline control
    always_comb begin
        en[pcr_pkg::NUM_STG-1] = !r_vld[pcr_pkg::NUM_STG-1] || i_out_ready;
        for (int k = pcr_pkg::NUM_STG-2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_in_ready  = en[pcr_pkg::STG_CLAMP];
    assign o_out_valid = r_vld[pcr_pkg::NUM_STG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < pcr_pkg::NUM_STG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ----------------------------------------------------------- clamp stage
    always_comb begin
        if (i_position[pcr_pkg::IN_W-1]) begin
            n_a_v = '0;
        end else if (i_position[pcr_pkg::POS_W-1:0] > pcr_pkg::POS_ONE) begin
            n_a_v = pcr_pkg::POS_ONE;
        end else begin
            n_a_v = i_position[pcr_pkg::POS_W-1:0];
        end
    end

    // ---------------------------------------------------------- search stage
    always_comb begin
        n_eff = (r_cnt > pcr_pkg::CNT_W'(pcr_pkg::MAX_BREAKS))
              ? pcr_pkg::CNT_W'(pcr_pkg::MAX_BREAKS) : r_cnt;

        hit = '0;
        for (int i = 1; i < pcr_pkg::NUM_BREAKS; i++) begin
            hit[i] = (pcr_pkg::CNT_W'(i) < n_eff) &&
                     (r_a_v >= r_brk[i-1].pos) && (r_a_v <= r_brk[i].pos);
        end

        // first enclosing segment wins; otherwise the last segment
        seg   = '0;
        found = 1'b0;
        for (int i = 1; i < pcr_pkg::NUM_BREAKS; i++) begin
            if (hit[i] && !found) begin
                seg[i] = 1'b1;
                found  = 1'b1;
            end
        end
        if (!found) begin
            for (int i = 1; i < pcr_pkg::NUM_BREAKS; i++) begin
                seg[i] = (pcr_pkg::CNT_W'(i) == n_eff - pcr_pkg::CNT_W'(1));
            end
        end

        n_sb          = '0;
        n_sb.v        = r_a_v;
        n_sb.fallback = !found;
        for (int i = 1; i < pcr_pkg::NUM_BREAKS; i++) begin
            if (seg[i]) begin
                n_sb.p1 = r_brk[i-1].pos;
                n_sb.c1 = r_brk[i-1].color;
                n_sb.p2 = r_brk[i].pos;
                n_sb.c2 = r_brk[i].color;
            end
        end

        // empty ramp gives white, single break gives its color
        if (n_eff == '0) begin
            n_sb.c1       = pcr_pkg::COL_WHITE;
            n_sb.force_c1 = 1'b1;
        end else if (n_eff == pcr_pkg::CNT_W'(1)) begin
            n_sb.c1       = r_brk[0].color;
            n_sb.force_c1 = 1'b1;
        end
    end

    // ------------------------------------------------------------ span stage
    always_comb begin
        logic [pcr_pkg::CH_W:0] diff;
        logic                   same;

        same        = (r_sb.p1 == r_sb.p2);
        n_sc        = '0;
        n_sc.span   = r_sb.p2 - r_sb.p1;
        n_sc.t      = r_sb.v - r_sb.p1;
        n_sc.use_c1 = r_sb.force_c1 || r_sb.fallback || same;
        // fallback puts v on the last break: result is c2 unless zero span
        n_sc.c1     = (r_sb.fallback && !r_sb.force_c1 && !same) ? r_sb.c2 : r_sb.c1;
        for (int ch = 0; ch < pcr_pkg::NUM_CH; ch++) begin
            diff         = {1'b0, r_sb.c2[ch]} - {1'b0, r_sb.c1[ch]};
            n_sc.neg[ch] = diff[pcr_pkg::CH_W];
            n_sc.mag[ch] = diff[pcr_pkg::CH_W] ? pcr_pkg::CH_W'(-diff)
                                               : diff[pcr_pkg::CH_W-1:0];
        end
    end

    // ---------------------------------------------- multiply and divide steps
    always_comb begin
        logic [pcr_pkg::NUM_W-1:0] sh;

        n_dv[0]        = '0;
        n_dv[0].span   = r_sc.span;
        n_dv[0].c1     = r_sc.c1;
        n_dv[0].neg    = r_sc.neg;
        n_dv[0].use_c1 = r_sc.use_c1;
        for (int ch = 0; ch < pcr_pkg::NUM_CH; ch++) begin
            n_dv[0].rem[ch] = pcr_pkg::NUM_W'(r_sc.mag[ch]) * pcr_pkg::NUM_W'(r_sc.t);
        end

        // restoring division, MSB first, one quotient bit per stage
        for (int j = 1; j <= pcr_pkg::DIV_STAGES; j++) begin
            n_dv[j] = r_dv[j-1];
            sh      = pcr_pkg::NUM_W'(r_dv[j-1].span) << (pcr_pkg::DIV_STAGES - j);
            for (int ch = 0; ch < pcr_pkg::NUM_CH; ch++) begin
                if (r_dv[j-1].rem[ch] >= sh) begin
                    n_dv[j].rem[ch]                          = r_dv[j-1].rem[ch] - sh;
                    n_dv[j].q[ch][pcr_pkg::DIV_STAGES - j] = 1'b1;
                end
            end
        end
    end

    // ---------------------------------------------------------- output stage
    always_comb begin
        for (int ch = 0; ch < pcr_pkg::NUM_CH; ch++) begin
            if (r_dv[pcr_pkg::DIV_STAGES].use_c1) begin
                n_out[ch] = r_dv[pcr_pkg::DIV_STAGES].c1[ch];
            end else if (r_dv[pcr_pkg::DIV_STAGES].neg[ch]) begin
                n_out[ch] = r_dv[pcr_pkg::DIV_STAGES].c1[ch] - r_dv[pcr_pkg::DIV_STAGES].q[ch];
            end else begin
                n_out[ch] = r_dv[pcr_pkg::DIV_STAGES].c1[ch] + r_dv[pcr_pkg::DIV_STAGES].q[ch];
            end
        end
    end

    // ------------------------------------------------------ payload registers
    always_ff @(posedge i_clk) begin
        if (en[pcr_pkg::STG_CLAMP]) begin
            r_a_v <= n_a_v;
        end
        if (en[pcr_pkg::STG_SEARCH]) begin
            r_sb <= n_sb;
        end
        if (en[pcr_pkg::STG_SPAN]) begin
            r_sc <= n_sc;
        end
        for (int j = 0; j <= pcr_pkg::DIV_STAGES; j++) begin
            if (en[pcr_pkg::STG_MUL + j]) begin
                r_dv[j] <= n_dv[j];
            end
        end
        if (en[pcr_pkg::NUM_STG-1]) begin
            r_out <= n_out;
        end
    end

    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];

endmodule

// ===== rtl/core/pcr_chk.sv =====
// Port-level checks for piecewise_color_ramp_top (module pcr_props), attached by bind.
// Depends on pcr_pkg.
`timescale 1ns / 1ps

module pcr_props (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_in_ready,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [pcr_pkg::CH_W-1:0]        o_red,
    input logic [pcr_pkg::CH_W-1:0]        o_green,
    input logic [pcr_pkg::CH_W-1:0]        o_blue
);

    // a stalled result transaction stays offered
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output valid dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_red) && $stable(o_green) && $stable(o_blue))
        else $error("output payload changed while stalled");

    // pipeline empty at the output end means every stage can move
    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> o_in_ready)
        else $error("input stalled while receiver is ready");

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind piecewise_color_ramp_top pcr_props u_pcr_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_red       (o_red),
    .o_green     (o_green),
    .o_blue      (o_blue)
);
